/* hw/rtl/npsel_pkg.sv */
// ----------------------------------------------------------------------------
// npsel_pkg
// Types and constants shared by the nearest points selector modules.
// ----------------------------------------------------------------------------
package npsel_pkg;

   localparam int COORD_W = 16;
   localparam int DIST_W  = 33;
   localparam int COUNT_W = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_REF_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF_Y = 1'b1;

   typedef struct packed {
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic                      first_of_set;
      logic                      last_of_set;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] out_x;
      logic signed [COORD_W-1:0] out_y;
      logic [COUNT_W-1:0]        kept_count;
      logic                      last_out;
   } rsp_type;

   // classified item handed from front to back
   typedef struct packed {
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic               first;
      logic               last;
      logic [DIST_W-1:0]  sq_dist;
   } item_type;

   // one kept slot
   typedef struct packed {
      logic [COORD_W-1:0] px;
      logic [COORD_W-1:0] py;
      logic [DIST_W-1:0]  sq_dist;
   } slot_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DECIDE,
      BK_EMIT
   } back_state_type;

endpackage

/* hw/rtl/npsel_front.sv */
// ----------------------------------------------------------------------------
// npsel_front
// Reference registers and squared distance pipeline; pushes items to queue.
// ----------------------------------------------------------------------------
module npsel_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  npsel_pkg::req_type                req_data,
   input  logic                              csr_we,
   input  logic [npsel_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [npsel_pkg::COORD_W-1:0]     csr_wdata,
   input  npsel_pkg::q_status_type           q_status,
   output logic                              push,
   output npsel_pkg::item_type               push_item
);

   logic [npsel_pkg::COORD_W-1:0] ref_x_ff, ref_x_in;
   logic [npsel_pkg::COORD_W-1:0] ref_y_ff, ref_y_in;
   logic                          s1_v_ff, s1_v_in;
   logic                          s2_v_ff, s2_v_in;
   npsel_pkg::req_type            s1_req_ff, s2_req_ff;
   logic [npsel_pkg::COORD_W-1:0] ax_ff, ax_in, ay_ff, ay_in;
   logic [2*npsel_pkg::COORD_W-1:0] sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [npsel_pkg::COORD_W:0]   dx, dy;
   logic                          accept;

   assign busy   = s1_v_ff | s2_v_ff | q_status.full;
   assign accept = start & ~busy;

   always_comb begin
      ref_x_in = ref_x_ff;
      ref_y_in = ref_y_ff;
      if (csr_we) begin
         unique case (csr_index)
            npsel_pkg::CSR_REF_X: ref_x_in = csr_wdata;
            npsel_pkg::CSR_REF_Y: ref_y_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // 17-bit exact differences, then magnitude (fits 16 bits)
   always_comb begin
      dx    = {req_data.point_x[npsel_pkg::COORD_W-1], req_data.point_x}
              - {ref_x_ff[npsel_pkg::COORD_W-1], ref_x_ff};
      dy    = {req_data.point_y[npsel_pkg::COORD_W-1], req_data.point_y}
              - {ref_y_ff[npsel_pkg::COORD_W-1], ref_y_ff};
      ax_in = dx[npsel_pkg::COORD_W] ? npsel_pkg::COORD_W'(~dx + 1'b1)
                                     : dx[npsel_pkg::COORD_W-1:0];
      ay_in = dy[npsel_pkg::COORD_W] ? npsel_pkg::COORD_W'(~dy + 1'b1)
                                     : dy[npsel_pkg::COORD_W-1:0];
      sqx_in = {{npsel_pkg::COORD_W{1'b0}}, ax_ff} * {{npsel_pkg::COORD_W{1'b0}}, ax_ff};
      sqy_in = {{npsel_pkg::COORD_W{1'b0}}, ay_ff} * {{npsel_pkg::COORD_W{1'b0}}, ay_ff};
      s1_v_in = accept;
      s2_v_in = s1_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff <= '0;
         ref_y_ff <= '0;
         s1_v_ff  <= 1'b0;
         s2_v_ff  <= 1'b0;
      end else begin
         ref_x_ff <= ref_x_in;
         ref_y_ff <= ref_y_in;
         s1_v_ff  <= s1_v_in;
         s2_v_ff  <= s2_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_req_ff <= req_data;
         ax_ff     <= ax_in;
         ay_ff     <= ay_in;
      end
      if (s1_v_ff) begin
         s2_req_ff <= s1_req_ff;
         sqx_ff    <= sqx_in;
         sqy_ff    <= sqy_in;
      end
   end

   assign push              = s2_v_ff;
   assign push_item.px      = s2_req_ff.point_x;
   assign push_item.py      = s2_req_ff.point_y;
   assign push_item.first   = s2_req_ff.first_of_set;
   assign push_item.last    = s2_req_ff.last_of_set;
   assign push_item.sq_dist = {1'b0, sqx_ff} + {1'b0, sqy_ff};

endmodule

/* hw/rtl/npsel_queue.sv */
// ----------------------------------------------------------------------------
// npsel_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
module npsel_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  npsel_pkg::item_type     push_item,
   input  logic                    pop,
   output npsel_pkg::item_type     head_item,
   output npsel_pkg::q_status_type q_status
);

   npsel_pkg::item_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item          = entry_ff[rd_ptr_ff];
   assign q_status.full      = count_ff[1];
   assign q_status.not_empty = (count_ff != 2'd0);

endmodule

/* hw/rtl/npsel_back.sv */
// ----------------------------------------------------------------------------
// npsel_back
// Slot memory, farthest-slot scan, replacement and set emission.
// ----------------------------------------------------------------------------
module npsel_back #(
   parameter int KEEP = 15
) (
   input  logic                    clock,
   input  logic                    reset,
   input  npsel_pkg::q_status_type q_status,
   input  npsel_pkg::item_type     head_item,
   output logic                    pop,
   output logic                    rsp_valid,
   output npsel_pkg::rsp_type      rsp_data
);

   localparam int IDX_W = (KEEP > 1) ? $clog2(KEEP) : 1;
   localparam int CNT_W = $clog2(KEEP + 1);

   npsel_pkg::back_state_type state_ff, state_in;

   npsel_pkg::slot_type mem [KEEP];
   npsel_pkg::slot_type rd_data_ff;
   npsel_pkg::slot_type wr_data;
   logic                wr_en, rd_en;
   logic [IDX_W-1:0]    wr_addr;

   npsel_pkg::item_type cur_ff, cur_in;
   logic [CNT_W-1:0]    fill_ff, fill_in, fill_eff;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                rd_v_ff, rd_v_in;
   logic [IDX_W-1:0]    rd_idx_ff;
   logic [npsel_pkg::DIST_W-1:0] best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic                out_v_ff, out_v_in;
   logic                out_last_ff, out_last_in;
   logic [npsel_pkg::COUNT_W-1:0] out_count_ff;
   logic [CNT_W+npsel_pkg::COUNT_W-1:0] fill_ext;
   logic                scan_done, emit_end, has_room;

   assign fill_eff  = head_item.first ? '0 : fill_ff;
   assign has_room  = (fill_eff < CNT_W'(KEEP));
   assign scan_done = rd_v_ff && (rd_idx_ff == IDX_W'(KEEP - 1));
   assign emit_end  = (cnt_ff == fill_ff - CNT_W'(1));
   assign fill_ext  = {{npsel_pkg::COUNT_W{1'b0}}, fill_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         npsel_pkg::BK_IDLE: begin
            if (q_status.not_empty) begin
               if (!has_room) begin
                  state_in = npsel_pkg::BK_SCAN;
               end else if (head_item.last) begin
                  state_in = npsel_pkg::BK_EMIT;
               end
            end
         end
         npsel_pkg::BK_SCAN: begin
            if (scan_done) begin
               state_in = npsel_pkg::BK_DECIDE;
            end
         end
         npsel_pkg::BK_DECIDE: begin
            state_in = cur_ff.last ? npsel_pkg::BK_EMIT : npsel_pkg::BK_IDLE;
         end
         npsel_pkg::BK_EMIT: begin
            if (emit_end) begin
               state_in = npsel_pkg::BK_IDLE;
            end
         end
         default: state_in = npsel_pkg::BK_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      pop          = 1'b0;
      cur_in       = cur_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      rd_en        = 1'b0;
      rd_v_in      = 1'b0;
      best_dist_in = best_dist_ff;
      best_idx_in  = best_idx_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      out_v_in     = 1'b0;
      out_last_in  = 1'b0;
      unique case (state_ff)
         npsel_pkg::BK_IDLE: begin
            cnt_in = '0;
            if (q_status.not_empty) begin
               pop    = 1'b1;
               cur_in = head_item;
               if (has_room) begin
                  wr_en           = 1'b1;
                  wr_addr         = fill_eff[IDX_W-1:0];
                  wr_data.px      = head_item.px;
                  wr_data.py      = head_item.py;
                  wr_data.sq_dist = head_item.sq_dist;
                  fill_in         = fill_eff + CNT_W'(1);
               end
            end
         end
         npsel_pkg::BK_SCAN: begin
            if (cnt_ff < CNT_W'(KEEP)) begin
               rd_en   = 1'b1;
               rd_v_in = 1'b1;
               cnt_in  = cnt_ff + CNT_W'(1);
            end
            // strict compare keeps the lowest slot among equals
            if (rd_v_ff && ((rd_idx_ff == '0) || (rd_data_ff.sq_dist > best_dist_ff))) begin
               best_dist_in = rd_data_ff.sq_dist;
               best_idx_in  = rd_idx_ff;
            end
         end
         npsel_pkg::BK_DECIDE: begin
            cnt_in = '0;
            if (cur_ff.sq_dist < best_dist_ff) begin
               wr_en           = 1'b1;
               wr_addr         = best_idx_ff;
               wr_data.px      = cur_ff.px;
               wr_data.py      = cur_ff.py;
               wr_data.sq_dist = cur_ff.sq_dist;
            end
         end
         npsel_pkg::BK_EMIT: begin
            rd_en       = 1'b1;
            cnt_in      = cnt_ff + CNT_W'(1);
            out_v_in    = 1'b1;
            out_last_in = emit_end;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= npsel_pkg::BK_IDLE;
         fill_ff  <= '0;
         rd_v_ff  <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         rd_v_ff  <= rd_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff       <= cur_in;
      cnt_ff       <= cnt_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      out_last_ff  <= out_last_in;
      out_count_ff <= fill_ext[npsel_pkg::COUNT_W-1:0];
      if (rd_en) begin
         rd_idx_ff <= cnt_ff[IDX_W-1:0];
      end
   end

   // slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[cnt_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid           = out_v_ff;
   assign rsp_data.out_x      = rd_data_ff.px;
   assign rsp_data.out_y      = rd_data_ff.py;
   assign rsp_data.kept_count = out_count_ff;
   assign rsp_data.last_out   = out_last_ff;

endmodule

/* hw/rtl/nearest_points_selector_top.sv */
// ----------------------------------------------------------------------------
// nearest_points_selector_top
// Keeps the KEEP points of a streamed set nearest a reference point and
// emits them in slot order on the last point of the set.
// ----------------------------------------------------------------------------
//  Channel   Ports                            Handshake
//  request   start, busy, req_data            taken when start & !busy
//  response  rsp_valid, rsp_data              one cycle per transaction
//  config    csr_we, csr_index, csr_wdata     written when csr_we
//
// Front: a request transaction passes difference, square and sum, the first two
// registered and the sum combinational; busy stays high meanwhile and while the
// two-entry queue is full. Back: a point that finds a free slot is written from
// idle; with the set full the slot memory is read one slot per cycle for the
// farthest slot, which the point replaces if nearer. Emission is in slot order.
// Reset is synchronous and empties queue and set; the slot memory is not
// cleared. Responses cannot be held off and leave at one per cycle.
// ----------------------------------------------------------------------------
module nearest_points_selector_top #(
   parameter int KEEP = 15
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  npsel_pkg::req_type                req_data,
   output logic                              rsp_valid,
   output npsel_pkg::rsp_type                rsp_data,
   input  logic                              csr_we,
   input  logic [npsel_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [npsel_pkg::COORD_W-1:0]     csr_wdata
);

   npsel_pkg::q_status_type q_status;
   npsel_pkg::item_type     push_item;
   npsel_pkg::item_type     head_item;
   logic                    push;
   logic                    pop;

   // front: reference registers and distance pipeline
   npsel_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   // decoupling queue
   npsel_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .q_status  (q_status)
   );

   // back: slot store, replacement and emission
   npsel_back #(
      .KEEP (KEEP)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .head_item (head_item),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
